@@ hdl/gjk_pkg.sv @@
// Shared types, constants and codes for the 2D convex collision core.
// Used by gjk_ctrl, gjk_dpath and gjk_convex_collision_2d_core; no dependencies.
package gjk_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ITER_W       = 8;
  localparam int PT_W         = COORD_BITS + 1;      // Minkowski point
  localparam int AB_W         = PT_W + 1;            // edge / negated point
  localparam int SUM_W        = COORD_BITS + ADDR_W; // vertex sums
  localparam int DIR_W        = CNT_W + SUM_W + 1;   // search direction
  localparam int MB_W         = SUM_W;               // multiplier B operand
  localparam int PROD_W       = DIR_W + MB_W;
  localparam int PSUM_W       = PROD_W + 1;
  localparam int NUM_MUL      = 4;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100);

  typedef enum logic [1:0] {
    CMD_VTX1 = 2'd0,
    CMD_VTX2 = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_LIMIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
  } in_word_t;

  typedef struct packed {
    logic       collision;
    logic [1:0] status;
    logic [7:0] iterations_used;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_SUM_CLR  = 4'd1,
    OP_SCAN_SUM = 4'd2,
    OP_SCAN_SUP = 4'd3,
    OP_DIR_MUL  = 4'd4,
    OP_DIR_SET  = 4'd5,
    OP_SUP_DONE = 4'd6,
    OP_ADOT_MUL = 4'd7,
    OP_INIT_SET = 4'd8,
    OP_SEG_MUL  = 4'd9,
    OP_SEG_SET  = 4'd10,
    OP_TRI_MUL  = 4'd11,
    OP_TRI_SGN  = 4'd12,
    OP_TRI_MUL2 = 4'd13,
    OP_TRI_SET  = 4'd14
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic              wr1;
    logic              wr2;
    logic [ADDR_W-1:0] wr_addr;
    logic              scan_valid;
    logic [ADDR_W-1:0] scan_addr;
    logic              scan_en1;
    logic              scan_en2;
    logic              scan_first;
    logic [CNT_W-1:0]  cnt1;
    logic [CNT_W-1:0]  cnt2;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic dot_pos;
    logic tri_hit;
  } dp_stat_t;

endpackage

@@ hdl/gjk_dpath.sv @@
// Datapath: vertex stores, scan pipeline, multiplier bank, simplex registers.
// Depends on gjk_pkg; driven by gjk_ctrl commands.
module gjk_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gjk_pkg::dp_cmd_t                 cmd_i,
  input  logic [gjk_pkg::COORD_BITS-1:0]   wr_x_i,
  input  logic [gjk_pkg::COORD_BITS-1:0]   wr_y_i,
  output gjk_pkg::dp_stat_t                stat_o
);

  localparam int CB     = gjk_pkg::COORD_BITS;
  localparam int PT_W   = gjk_pkg::PT_W;
  localparam int AB_W   = gjk_pkg::AB_W;
  localparam int SUM_W  = gjk_pkg::SUM_W;
  localparam int DIR_W  = gjk_pkg::DIR_W;
  localparam int MB_W   = gjk_pkg::MB_W;
  localparam int PROD_W = gjk_pkg::PROD_W;
  localparam int PSUM_W = gjk_pkg::PSUM_W;
  localparam int NM     = gjk_pkg::NUM_MUL;

  logic [2*CB-1:0] mem1 [gjk_pkg::MAX_VERTICES];
  logic [2*CB-1:0] mem2 [gjk_pkg::MAX_VERTICES];
  logic [2*CB-1:0] rd1_q, rd2_q, vtx1_s2_q, vtx2_s2_q;

  logic v1_q, v2_q;
  logic en1_s1_q, en2_s1_q, first_s1_q;
  logic en1_s2_q, en2_s2_q, first_s2_q;

  logic signed [CB-1:0]     rd1x, rd1y, rd2x, rd2y;
  logic signed [DIR_W-1:0]  opa [NM];
  logic signed [MB_W-1:0]   opb [NM];
  logic signed [PROD_W-1:0] prod_q [NM];
  logic signed [PSUM_W-1:0] sum01, sum23, diff01, diff23;

  logic signed [SUM_W-1:0]  s1x_q, s1y_q, s2x_q, s2y_q;
  logic signed [DIR_W-1:0]  dx_q, dy_q;
  logic signed [PSUM_W-1:0] best1_q, best2_q;
  logic signed [CB-1:0]     b1x_q, b1y_q, b2x_q, b2y_q;
  logic signed [PT_W-1:0]   ax_q, ay_q, sp0x_q, sp0y_q, sp1x_q, sp1y_q;
  logic                     sgn_pos_q, sgn_neg_q;

  logic signed [AB_W-1:0]   e0x, e0y, e1x, e1y, aox, aoy, px, py, qx, qy;

  // vertex stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr1) mem1[cmd_i.wr_addr] <= {wr_x_i, wr_y_i};
    if (cmd_i.scan_valid) rd1_q <= mem1[cmd_i.scan_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr2) mem2[cmd_i.wr_addr] <= {wr_x_i, wr_y_i};
    if (cmd_i.scan_valid) rd2_q <= mem2[cmd_i.scan_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_valid) begin
      en1_s1_q   <= cmd_i.scan_en1;
      en2_s1_q   <= cmd_i.scan_en2;
      first_s1_q <= cmd_i.scan_first;
    end
    if (v1_q) begin
      en1_s2_q   <= en1_s1_q;
      en2_s2_q   <= en2_s1_q;
      first_s2_q <= first_s1_q;
      vtx1_s2_q  <= rd1_q;
      vtx2_s2_q  <= rd2_q;
    end
  end

  assign rd1x = $signed(rd1_q[2*CB-1:CB]);
  assign rd1y = $signed(rd1_q[CB-1:0]);
  assign rd2x = $signed(rd2_q[2*CB-1:CB]);
  assign rd2y = $signed(rd2_q[CB-1:0]);

  // e0 = simplex[0] - a, e1 = simplex[1] - a, ao = -a
  assign e0x = AB_W'(sp0x_q) - AB_W'(ax_q);
  assign e0y = AB_W'(sp0y_q) - AB_W'(ay_q);
  assign e1x = AB_W'(sp1x_q) - AB_W'(ax_q);
  assign e1y = AB_W'(sp1y_q) - AB_W'(ay_q);
  assign aox = -AB_W'(ax_q);
  assign aoy = -AB_W'(ay_q);

  // triangle normals scaled by the winding sign
  assign px = sgn_pos_q ? -e0y : (sgn_neg_q ? e0y : '0);
  assign py = sgn_pos_q ? e0x : (sgn_neg_q ? -e0x : '0);
  assign qx = sgn_pos_q ? e1y : (sgn_neg_q ? -e1y : '0);
  assign qy = sgn_pos_q ? -e1x : (sgn_neg_q ? e1x : '0);

  always_comb begin
    for (int k = 0; k < NM; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    unique case (cmd_i.op)
      gjk_pkg::OP_SCAN_SUP: begin
        opa[0] = dx_q; opb[0] = MB_W'(rd1x);
        opa[1] = dy_q; opb[1] = MB_W'(rd1y);
        opa[2] = dx_q; opb[2] = MB_W'(rd2x);
        opa[3] = dy_q; opb[3] = MB_W'(rd2y);
      end
      gjk_pkg::OP_DIR_MUL: begin
        opa[0] = DIR_W'($signed({1'b0, cmd_i.cnt2})); opb[0] = s1x_q;
        opa[1] = DIR_W'($signed({1'b0, cmd_i.cnt1})); opb[1] = s2x_q;
        opa[2] = DIR_W'($signed({1'b0, cmd_i.cnt2})); opb[2] = s1y_q;
        opa[3] = DIR_W'($signed({1'b0, cmd_i.cnt1})); opb[3] = s2y_q;
      end
      gjk_pkg::OP_ADOT_MUL: begin
        opa[0] = dx_q; opb[0] = MB_W'(ax_q);
        opa[1] = dy_q; opb[1] = MB_W'(ay_q);
      end
      gjk_pkg::OP_SEG_MUL: begin
        opa[0] = DIR_W'(e0x); opb[0] = MB_W'(aoy);
        opa[1] = DIR_W'(e0y); opb[1] = MB_W'(aox);
      end
      gjk_pkg::OP_TRI_MUL: begin
        opa[0] = DIR_W'(e1x); opb[0] = MB_W'(e0y);
        opa[1] = DIR_W'(e1y); opb[1] = MB_W'(e0x);
      end
      gjk_pkg::OP_TRI_MUL2: begin
        opa[0] = DIR_W'(px); opb[0] = MB_W'(aox);
        opa[1] = DIR_W'(py); opb[1] = MB_W'(aoy);
        opa[2] = DIR_W'(qx); opb[2] = MB_W'(aox);
        opa[3] = DIR_W'(qy); opb[3] = MB_W'(aoy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NM; k++) begin
      prod_q[k] <= opa[k] * opb[k];
    end
  end

  assign sum01  = PSUM_W'(prod_q[0]) + PSUM_W'(prod_q[1]);
  assign sum23  = PSUM_W'(prod_q[2]) + PSUM_W'(prod_q[3]);
  assign diff01 = PSUM_W'(prod_q[0]) - PSUM_W'(prod_q[1]);
  assign diff23 = PSUM_W'(prod_q[2]) - PSUM_W'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      gjk_pkg::OP_SUM_CLR: begin
        s1x_q <= '0; s1y_q <= '0;
        s2x_q <= '0; s2y_q <= '0;
      end
      gjk_pkg::OP_SCAN_SUM: begin
        if (v1_q && en1_s1_q) begin
          s1x_q <= s1x_q + SUM_W'(rd1x);
          s1y_q <= s1y_q + SUM_W'(rd1y);
        end
        if (v1_q && en2_s1_q) begin
          s2x_q <= s2x_q + SUM_W'(rd2x);
          s2y_q <= s2y_q + SUM_W'(rd2y);
        end
      end
      gjk_pkg::OP_SCAN_SUP: begin
        // first vertex wins ties; body 2 searches along -d, so keep the minimum
        if (v2_q && en1_s2_q && (first_s2_q || sum01 > best1_q)) begin
          best1_q <= sum01;
          b1x_q   <= $signed(vtx1_s2_q[2*CB-1:CB]);
          b1y_q   <= $signed(vtx1_s2_q[CB-1:0]);
        end
        if (v2_q && en2_s2_q && (first_s2_q || sum23 < best2_q)) begin
          best2_q <= sum23;
          b2x_q   <= $signed(vtx2_s2_q[2*CB-1:CB]);
          b2y_q   <= $signed(vtx2_s2_q[CB-1:0]);
        end
      end
      gjk_pkg::OP_DIR_SET: begin
        if (diff01 == 0 && diff23 == 0) begin
          dx_q <= DIR_W'(1);
          dy_q <= '0;
        end else begin
          dx_q <= DIR_W'(diff01);
          dy_q <= DIR_W'(diff23);
        end
      end
      gjk_pkg::OP_SUP_DONE: begin
        ax_q <= PT_W'(b1x_q) - PT_W'(b2x_q);
        ay_q <= PT_W'(b1y_q) - PT_W'(b2y_q);
      end
      gjk_pkg::OP_INIT_SET: begin
        sp0x_q <= ax_q;
        sp0y_q <= ay_q;
        dx_q   <= DIR_W'(aox);
        dy_q   <= DIR_W'(aoy);
      end
      gjk_pkg::OP_SEG_SET: begin
        // zero triple product falls back to the same perpendicular as negative
        if (diff01 > 0) begin
          dx_q <= DIR_W'(-e0y);
          dy_q <= DIR_W'(e0x);
        end else begin
          dx_q <= DIR_W'(e0y);
          dy_q <= DIR_W'(-e0x);
        end
        sp1x_q <= ax_q;
        sp1y_q <= ay_q;
      end
      gjk_pkg::OP_TRI_SGN: begin
        sgn_pos_q <= diff01 > 0;
        sgn_neg_q <= diff01 < 0;
      end
      gjk_pkg::OP_TRI_SET: begin
        if (sum01 >= 0) begin
          dx_q <= DIR_W'(px);
          dy_q <= DIR_W'(py);
        end else begin
          sp0x_q <= sp1x_q;
          sp0y_q <= sp1y_q;
          dx_q   <= DIR_W'(qx);
          dy_q   <= DIR_W'(qy);
        end
        sp1x_q <= ax_q;
        sp1y_q <= ay_q;
      end
      default: ;
    endcase
  end

  assign stat_o.scan_busy = v1_q | v2_q;
  assign stat_o.dot_pos   = sum01 > 0;
  assign stat_o.tri_hit   = (sum01 < 0) && (sum23 < 0);

endmodule

@@ hdl/gjk_ctrl.sv @@
// Controller: input handshake, vertex counts, test sequencer, result register.
// Depends on gjk_pkg; commands gjk_dpath through dp_cmd_t.
module gjk_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gjk_pkg::out_word_t            out_word_o,
  input  logic [gjk_pkg::ITER_W-1:0]    max_iter_i,
  output gjk_pkg::dp_cmd_t              cmd_o,
  input  gjk_pkg::dp_stat_t             stat_i
);

  localparam int CNT_W  = gjk_pkg::CNT_W;
  localparam int ADDR_W = gjk_pkg::ADDR_W;
  localparam int ITER_W = gjk_pkg::ITER_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(gjk_pkg::MAX_VERTICES);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_START   = 17'h00002,
    S_SUM     = 17'h00004,
    S_DIRMUL  = 17'h00008,
    S_DIRSET  = 17'h00010,
    S_SUP     = 17'h00020,
    S_SUPDONE = 17'h00040,
    S_AMUL    = 17'h00080,
    S_ACHK    = 17'h00100,
    S_LOOP    = 17'h00200,
    S_SMUL    = 17'h00400,
    S_SSET    = 17'h00800,
    S_TMUL    = 17'h01000,
    S_TSGN    = 17'h02000,
    S_TMUL2   = 17'h04000,
    S_TSET    = 17'h08000,
    S_RESULT  = 17'h10000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt1_q, cnt1_d, cnt2_q, cnt2_d, scan_idx_q, scan_idx_d, max_cnt;
  logic                   ovf_q, ovf_d, init_q, init_d, tri_q, tri_d;
  logic [ITER_W-1:0]      iter_q, iter_d, res_iter_q, res_iter_d;
  logic                   res_hit_q, res_hit_d;
  gjk_pkg::status_e       res_st_q, res_st_d;
  logic                   out_valid_q, out_valid_d;
  gjk_pkg::out_word_t     out_word_q, out_word_d;
  logic                   in_acc, issue, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign max_cnt    = (cnt1_q > cnt2_q) ? cnt1_q : cnt2_q;
  assign issue      = (state_q == S_SUM || state_q == S_SUP) && (scan_idx_q < max_cnt);
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    cnt1_d     = cnt1_q;
    cnt2_d     = cnt2_q;
    ovf_d      = ovf_q;
    scan_idx_d = scan_idx_q;
    init_d     = init_q;
    tri_d      = tri_q;
    iter_d     = iter_q;
    res_hit_d  = res_hit_q;
    res_st_d   = res_st_q;
    res_iter_d = res_iter_q;

    cmd_o            = '0;
    cmd_o.op         = gjk_pkg::OP_NONE;
    cmd_o.cnt1       = cnt1_q;
    cmd_o.cnt2       = cnt2_q;
    cmd_o.scan_valid = issue;
    cmd_o.scan_addr  = scan_idx_q[ADDR_W-1:0];
    cmd_o.scan_en1   = scan_idx_q < cnt1_q;
    cmd_o.scan_en2   = scan_idx_q < cnt2_q;
    cmd_o.scan_first = (scan_idx_q == '0);
    if (issue) scan_idx_d = scan_idx_q + CNT_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            gjk_pkg::CMD_VTX1: begin
              if (cnt1_q >= CNT_FULL) ovf_d = 1'b1;
              else begin
                cmd_o.wr1     = 1'b1;
                cmd_o.wr_addr = cnt1_q[ADDR_W-1:0];
                cnt1_d        = cnt1_q + CNT_W'(1);
              end
            end
            gjk_pkg::CMD_VTX2: begin
              if (cnt2_q >= CNT_FULL) ovf_d = 1'b1;
              else begin
                cmd_o.wr2     = 1'b1;
                cmd_o.wr_addr = cnt2_q[ADDR_W-1:0];
                cnt2_d        = cnt2_q + CNT_W'(1);
              end
            end
            gjk_pkg::CMD_RUN: begin
              res_hit_d  = 1'b0;
              res_iter_d = '0;
              if (cnt1_q == '0 || cnt2_q == '0) begin
                res_st_d = gjk_pkg::ST_EMPTY;
                state_d  = S_RESULT;
              end else if (ovf_q) begin
                res_st_d = gjk_pkg::ST_OVERFLOW;
                state_d  = S_RESULT;
              end else begin
                state_d = S_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        cmd_o.op   = gjk_pkg::OP_SUM_CLR;
        scan_idx_d = '0;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = gjk_pkg::OP_SCAN_SUM;
        if (!issue && !stat_i.scan_busy) state_d = S_DIRMUL;
      end
      S_DIRMUL: begin
        cmd_o.op = gjk_pkg::OP_DIR_MUL;
        state_d  = S_DIRSET;
      end
      S_DIRSET: begin
        cmd_o.op   = gjk_pkg::OP_DIR_SET;
        scan_idx_d = '0;
        iter_d     = '0;
        init_d     = 1'b1;
        tri_d      = 1'b0;
        state_d    = S_SUP;
      end
      S_SUP: begin
        cmd_o.op = gjk_pkg::OP_SCAN_SUP;
        if (!issue && !stat_i.scan_busy) state_d = S_SUPDONE;
      end
      S_SUPDONE: begin
        cmd_o.op = gjk_pkg::OP_SUP_DONE;
        state_d  = S_AMUL;
      end
      S_AMUL: begin
        cmd_o.op = gjk_pkg::OP_ADOT_MUL;
        state_d  = S_ACHK;
      end
      S_ACHK: begin
        if (!stat_i.dot_pos) begin
          res_hit_d  = 1'b0;
          res_st_d   = gjk_pkg::ST_OK;
          res_iter_d = iter_q;
          state_d    = S_RESULT;
        end else if (init_q) begin
          cmd_o.op = gjk_pkg::OP_INIT_SET;
          init_d   = 1'b0;
          state_d  = S_LOOP;
        end else begin
          state_d = tri_q ? S_TMUL : S_SMUL;
        end
      end
      S_LOOP: begin
        if (iter_q >= max_iter_i) begin
          res_hit_d  = 1'b0;
          res_st_d   = gjk_pkg::ST_LIMIT;
          res_iter_d = iter_q;
          state_d    = S_RESULT;
        end else begin
          iter_d     = iter_q + ITER_W'(1);
          scan_idx_d = '0;
          state_d    = S_SUP;
        end
      end
      S_SMUL: begin
        cmd_o.op = gjk_pkg::OP_SEG_MUL;
        state_d  = S_SSET;
      end
      S_SSET: begin
        cmd_o.op = gjk_pkg::OP_SEG_SET;
        tri_d    = 1'b1;
        state_d  = S_LOOP;
      end
      S_TMUL: begin
        cmd_o.op = gjk_pkg::OP_TRI_MUL;
        state_d  = S_TSGN;
      end
      S_TSGN: begin
        cmd_o.op = gjk_pkg::OP_TRI_SGN;
        state_d  = S_TMUL2;
      end
      S_TMUL2: begin
        cmd_o.op = gjk_pkg::OP_TRI_MUL2;
        state_d  = S_TSET;
      end
      S_TSET: begin
        if (stat_i.tri_hit) begin
          res_hit_d  = 1'b1;
          res_st_d   = gjk_pkg::ST_OK;
          res_iter_d = iter_q;
          state_d    = S_RESULT;
        end else begin
          cmd_o.op = gjk_pkg::OP_TRI_SET;
          state_d  = S_LOOP;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          cnt1_d  = '0;
          cnt2_d  = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_load) begin
      out_valid_d                = 1'b1;
      out_word_d.collision       = res_hit_q;
      out_word_d.status          = res_st_q;
      out_word_d.iterations_used = res_iter_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      ovf_q       <= 1'b0;
      scan_idx_q  <= '0;
      init_q      <= 1'b0;
      tri_q       <= 1'b0;
      iter_q      <= '0;
      res_hit_q   <= 1'b0;
      res_st_q    <= gjk_pkg::ST_OK;
      res_iter_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      ovf_q       <= ovf_d;
      scan_idx_q  <= scan_idx_d;
      init_q      <= init_d;
      tri_q       <= tri_d;
      iter_q      <= iter_d;
      res_hit_q   <= res_hit_d;
      res_st_q    <= res_st_d;
      res_iter_q  <= res_iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i == gjk_pkg::CMD_RUN) |=> (state_q == S_START || state_q == S_RESULT))
    else $error("run word did not start a test or result");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result word appeared outside result state");

  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (cnt1_q == '0 && cnt2_q == '0 && !ovf_q))
    else $error("stores not cleared after result");

  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.scan_busy |-> (state_q == S_SUM || state_q == S_SUP))
    else $error("scan pipeline busy after leaving scan state");
`endif

endmodule

@@ hdl/gjk_convex_collision_2d_core.sv @@
// Top level of the 2D convex polygon collision core (GJK yes/no test).
// Depends on gjk_pkg, gjk_ctrl and gjk_dpath; holds the APB config register.

// Vertex words (command 0 or 1) are taken one per cycle into two 128-entry
// stores; a full store drops the vertex and flags overflow. A run word
// (command 2) stalls the input until its single result word is produced and
// clears both stores. With N the larger vertex count and k the refinement
// iterations, a run first scans N entries for the mean-point sums and
// direction, then makes (k + 1) support passes over N entries, each
// followed by up to one simplex update; every scan reads one vertex of each
// body per cycle through the single read port of each store.
// Command 3 is ignored. max_iterations (APB byte address 0, reset 100)
// bounds the refinement loop; write it only while no test is running.
module gjk_convex_collision_2d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gjk_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gjk_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] ADDR_MAX_ITER = 2'd0;

  logic [gjk_pkg::ITER_W-1:0] max_iter_q;
  gjk_pkg::dp_cmd_t           dp_cmd;
  gjk_pkg::dp_stat_t          dp_stat;

  // config register: written on the APB access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= gjk_pkg::ITER_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_ITER) begin
      max_iter_q <= pwdata[gjk_pkg::ITER_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_ITER) ? 32'(max_iter_q) : '0;

  gjk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (in_word_i.command),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .max_iter_i  (max_iter_q),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // coordinates keep their low COORD_BITS bits as two's complement
  gjk_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dp_cmd),
    .wr_x_i (in_word_i.x_coord[gjk_pkg::COORD_BITS-1:0]),
    .wr_y_i (in_word_i.y_coord[gjk_pkg::COORD_BITS-1:0]),
    .stat_o (dp_stat)
  );

endmodule
